// ----- rtl/rvag_pkg.sv -----
package rvag_pkg;

   localparam int SQ_W      = 31;
   localparam int THR_W     = 31;
   localparam int LENGTH_W  = 24;
   localparam int CNT_W     = 25;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DAT_W = 31;
   localparam int REQ_DAT_W = 16;
   localparam int RSP_DAT_W = 8;

   localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};

   localparam logic [CSR_IDX_W-1:0] CSR_THRESHOLD_POWER = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ATTACK_LENGTH   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_RELEASE_LENGTH  = 2'd2;

   localparam logic [THR_W-1:0]    THRESHOLD_RESET = 31'd107374;
   localparam logic [LENGTH_W-1:0] ATTACK_RESET    = 24'd480;
   localparam logic [LENGTH_W-1:0] RELEASE_RESET   = 24'd9600;

   typedef struct packed {
      logic empty;
      logic room;
   } queue_status_type;

   typedef struct packed {
      logic [THR_W-1:0]    threshold_power;
      logic [LENGTH_W-1:0] attack_length;
      logic [LENGTH_W-1:0] release_length;
   } gate_cfg_type;

endpackage

// ----- rtl/block_rms_voice_activity_gate_top.sv -----
// channel   dir  beat fields (low bit up)           handshake
// req_      in   tdata: sample[15:0]; tlast: last   req_tvalid & req_tready
// rsp_      out  tdata: active[0], above[1]         rsp_tvalid & rsp_tready
// csr_      in   index 0 threshold, 1 attack, 2 release   csr_we
// one sample beat per cycle while req_tready is high; the square stage and the accumulator run at that rate
// after the edge that takes its final beat, a block result passes the accumulator and queue,
// the product stage and the output register before it is offered
// reset is synchronous; the control registers and CSRs return to their default values, data registers are not reset
// fewer than two free queue slots drop req_tready; rsp_tready low holds the output register
module block_rms_voice_activity_gate_top #(
   parameter int MAX_BLOCK   = 4096,
   parameter int QUEUE_DEPTH = 4
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [rvag_pkg::REQ_DAT_W-1:0] req_tdata,  // sample[15:0]
   input  logic                           req_tlast,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [rvag_pkg::RSP_DAT_W-1:0] rsp_tdata,  // active[0], above[1], zero
   input  logic                           csr_we,
   input  logic [rvag_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [rvag_pkg::CSR_DAT_W-1:0] csr_wdata
);

   localparam int LEN_W = $clog2(MAX_BLOCK + 1);
   localparam int SUM_W = rvag_pkg::SQ_W - 1 + LEN_W;

   rvag_pkg::queue_status_type status;
   rvag_pkg::gate_cfg_type     cfg_ff, cfg_in;

   logic                       push, pop;
   logic [SUM_W-1:0]           push_sum;
   logic [LEN_W-1:0]           push_len;
   logic [LEN_W+SUM_W-1:0]     pop_data;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            rvag_pkg::CSR_THRESHOLD_POWER: begin
               cfg_in.threshold_power = csr_wdata[rvag_pkg::THR_W-1:0];
            end
            rvag_pkg::CSR_ATTACK_LENGTH: begin
               cfg_in.attack_length = csr_wdata[rvag_pkg::LENGTH_W-1:0];
            end
            rvag_pkg::CSR_RELEASE_LENGTH: begin
               cfg_in.release_length = csr_wdata[rvag_pkg::LENGTH_W-1:0];
            end
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.threshold_power <= rvag_pkg::THRESHOLD_RESET;
         cfg_ff.attack_length   <= rvag_pkg::ATTACK_RESET;
         cfg_ff.release_length  <= rvag_pkg::RELEASE_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   rvag_front #(
      .MAX_BLOCK (MAX_BLOCK),
      .LEN_W     (LEN_W),
      .SUM_W     (SUM_W)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .status     (status),
      .push       (push),
      .push_sum   (push_sum),
      .push_len   (push_len)
   );

   rvag_queue #(
      .DATA_W (LEN_W + SUM_W),
      .DEPTH  (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data ({push_len, push_sum}),
      .pop       (pop),
      .pop_data  (pop_data),
      .status    (status)
   );

   rvag_back #(
      .LEN_W (LEN_W),
      .SUM_W (SUM_W)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .status     (status),
      .pop        (pop),
      .pop_sum    (pop_data[SUM_W-1:0]),
      .pop_len    (pop_data[LEN_W+SUM_W-1:SUM_W]),
      .cfg        (cfg_ff),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

// ----- rtl/rvag_front.sv -----
module rvag_front #(
   parameter int MAX_BLOCK = 4096,
   parameter int LEN_W     = 13,
   parameter int SUM_W     = 43
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [rvag_pkg::REQ_DAT_W-1:0] req_tdata,
   input  logic                          req_tlast,
   input  rvag_pkg::queue_status_type    status,
   output logic                          push,
   output logic [SUM_W-1:0]              push_sum,
   output logic [LEN_W-1:0]              push_len
);

   logic signed [31:0]            product;
   logic [rvag_pkg::SQ_W-1:0]     sq_ff, sq_in;
   logic                          sq_last_ff, sq_last_in;
   logic                          sq_valid_ff, sq_valid_in;
   logic [SUM_W-1:0]              sum_ff, sum_in;
   logic [LEN_W-1:0]              len_ff, len_in;
   logic [SUM_W-1:0]              acc;
   logic [LEN_W:0]                len_next;
   logic                          blk_end;
   logic                          accept;

   assign req_tready = status.room;
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      product     = $signed(req_tdata) * $signed(req_tdata);
      sq_in       = product[rvag_pkg::SQ_W-1:0];
      sq_last_in  = req_tlast;
      sq_valid_in = accept;

      acc      = sum_ff + SUM_W'(sq_ff);
      len_next = {1'b0, len_ff} + {{LEN_W{1'b0}}, 1'b1};
      blk_end  = sq_last_ff || (len_next == (LEN_W+1)'(MAX_BLOCK));
      push     = sq_valid_ff && blk_end;
      push_sum = acc;
      push_len = len_next[LEN_W-1:0];

      sum_in = sum_ff;
      len_in = len_ff;
      if (sq_valid_ff) begin
         if (blk_end) begin
            sum_in = '0;
            len_in = '0;
         end else begin
            sum_in = acc;
            len_in = len_next[LEN_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sq_valid_ff <= 1'b0;
         sum_ff      <= '0;
         len_ff      <= '0;
      end else begin
         sq_valid_ff <= sq_valid_in;
         sum_ff      <= sum_in;
         len_ff      <= len_in;
      end
      if (accept) begin
         sq_ff      <= sq_in;
         sq_last_ff <= sq_last_in;
      end
   end

endmodule

// ----- rtl/rvag_queue.sv -----
module rvag_queue #(
   parameter int DATA_W = 56,
   parameter int DEPTH  = 4
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  logic [DATA_W-1:0]          push_data,
   input  logic                       pop,
   output logic [DATA_W-1:0]          pop_data,
   output rvag_pkg::queue_status_type status
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [DATA_W-1:0] mem [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      count_in = count_ff + CNT_W'(push) - CNT_W'(pop);

      pop_data     = mem[rd_ptr_ff];
      status.empty = (count_ff == '0);
      // one slot kept for the beat still in the square stage
      status.room  = (count_ff <= CNT_W'(DEPTH - 2));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         mem[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ----- rtl/rvag_back.sv -----
module rvag_back #(
   parameter int LEN_W = 13,
   parameter int SUM_W = 43
) (
   input  logic                           clock,
   input  logic                           reset,
   input  rvag_pkg::queue_status_type     status,
   output logic                           pop,
   input  logic [SUM_W-1:0]               pop_sum,
   input  logic [LEN_W-1:0]               pop_len,
   input  rvag_pkg::gate_cfg_type         cfg,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [rvag_pkg::RSP_DAT_W-1:0] rsp_tdata
);

   localparam int PROD_W = LEN_W + rvag_pkg::THR_W;
   localparam int CMP_W  = (PROD_W > SUM_W) ? PROD_W : SUM_W;
   localparam int CW     = rvag_pkg::CNT_W;

   logic                 v1_ff, v1_in;
   logic [PROD_W-1:0]    prod_ff, prod_in;
   logic [SUM_W-1:0]     sum1_ff;
   logic [LEN_W-1:0]     len1_ff;

   logic                 out_valid_ff, out_valid_in;
   logic                 out_active_ff, out_active_in;
   logic                 out_above_ff, out_above_in;
   logic                 gate_ff, gate_in;
   logic [CW-1:0]        attack_ff, attack_in;
   logic [CW-1:0]        release_ff, release_in;

   logic                 out_en, en1, load2, above;
   logic [CW:0]          att_sum, rel_sum;
   logic [CW-1:0]        att_sat, rel_sat;

   always_comb begin
      out_en  = !out_valid_ff || rsp_tready;
      en1     = !v1_ff || out_en;
      pop     = !status.empty && en1;
      load2   = v1_ff && out_en;
      v1_in   = en1 ? !status.empty : v1_ff;
      prod_in = PROD_W'(pop_len) * PROD_W'(cfg.threshold_power);

      above = (sum1_ff != '0) && (CMP_W'(sum1_ff) >= CMP_W'(prod_ff));

      att_sum = {1'b0, attack_ff} + (CW+1)'(len1_ff);
      rel_sum = {1'b0, release_ff} + (CW+1)'(len1_ff);
      att_sat = (att_sum > (CW+1)'(rvag_pkg::COUNT_MAX)) ? rvag_pkg::COUNT_MAX
                                                          : att_sum[CW-1:0];
      rel_sat = (rel_sum > (CW+1)'(rvag_pkg::COUNT_MAX)) ? rvag_pkg::COUNT_MAX
                                                          : rel_sum[CW-1:0];

      gate_in       = gate_ff;
      attack_in     = attack_ff;
      release_in    = release_ff;
      out_active_in = out_active_ff;
      out_above_in  = out_above_ff;
      out_valid_in  = out_valid_ff && !rsp_tready;
      if (load2) begin
         if (above) begin
            release_in = '0;
            if (!gate_ff) begin
               if (att_sat >= CW'(cfg.attack_length)) begin
                  gate_in   = 1'b1;
                  attack_in = '0;
               end else begin
                  attack_in = att_sat;
               end
            end
         end else begin
            attack_in = '0;
            if (gate_ff) begin
               if (rel_sat >= CW'(cfg.release_length)) begin
                  gate_in    = 1'b0;
                  release_in = '0;
               end else begin
                  release_in = rel_sat;
               end
            end
         end
         out_valid_in  = 1'b1;
         out_active_in = gate_in;
         out_above_in  = above;
      end

      rsp_tvalid = out_valid_ff;
      rsp_tdata  = {{(rvag_pkg::RSP_DAT_W-2){1'b0}}, out_above_ff, out_active_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         out_valid_ff <= 1'b0;
         gate_ff      <= 1'b0;
         attack_ff    <= '0;
         release_ff   <= '0;
      end else begin
         v1_ff        <= v1_in;
         out_valid_ff <= out_valid_in;
         gate_ff      <= gate_in;
         attack_ff    <= attack_in;
         release_ff   <= release_in;
      end
      if (pop) begin
         prod_ff <= prod_in;
         sum1_ff <= pop_sum;
         len1_ff <= pop_len;
      end
      out_active_ff <= out_active_in;
      out_above_ff  <= out_above_in;
   end

endmodule

// ----- tb/tb_block_rms_voice_activity_gate_top.sv -----
module tb_block_rms_voice_activity_gate_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int BLOCK_LIMIT   = 4096;
   localparam int PHASES        = 8;
   localparam int PHASE_BEATS   = 244;
   localparam int HOLD_CYCLES   = 300;
   localparam int BURST_BEATS   = 40;
   localparam int SETTLE_CYCLES = 8;
   localparam int CYCLE_LIMIT   = 1000000;
   localparam int PLAN_LEN      = 32;

   localparam logic [rvag_pkg::CSR_IDX_W-1:0] CSR_UNUSED = 2'd3;

   typedef struct packed {
      logic active;
      logic above;
   } gate_verdict_type;

   typedef enum logic {ROW_BEAT, ROW_WRITE} row_kind_type;

   typedef struct packed {
      row_kind_type                   kind;
      logic [rvag_pkg::CSR_IDX_W-1:0] reg_sel;
      logic [rvag_pkg::CSR_DAT_W-1:0] value;
      logic [rvag_pkg::REQ_DAT_W-1:0] pcm;
      logic                           lst;
      gate_verdict_type               verdict;
   } plan_row_type;

   typedef enum int {LEVEL_SILENT, LEVEL_FAINT, LEVEL_MID, LEVEL_FULL, LEVEL_PEAK} level_type;

   logic                           clock;
   logic                           reset      = 1'b1;
   logic                           req_tvalid = 1'b0;
   logic                           req_tready;
   logic [rvag_pkg::REQ_DAT_W-1:0] req_tdata  = '0;  // sample[15:0]
   logic                           req_tlast  = 1'b0;
   logic                           rsp_tvalid;
   logic                           rsp_tready = 1'b0;
   logic [rvag_pkg::RSP_DAT_W-1:0] rsp_tdata;         // active[0], above[1], zero
   logic                           csr_we     = 1'b0;
   logic [rvag_pkg::CSR_IDX_W-1:0] csr_index  = '0;
   logic [rvag_pkg::CSR_DAT_W-1:0] csr_wdata  = '0;

   // side info riding along with each sample beat
   logic                  tag_valid  = 1'b0;
   gate_verdict_type      tag_value  = '0;

   logic                  calm       = 1'b0;
   logic                  hold_req   = 1'b0;
   logic                  hold_used  = 1'b0;

   int unsigned           cycle_count = 0;
   int unsigned           mismatches  = 0;

   // predictor state
   logic [rvag_pkg::THR_W-1:0]    thr_level;
   logic [rvag_pkg::LENGTH_W-1:0] attack_len;
   logic [rvag_pkg::LENGTH_W-1:0] release_len;
   logic [42:0]                   energy_sum;
   logic [12:0]                   beat_count;
   logic [rvag_pkg::CNT_W-1:0]    attack_run;
   logic [rvag_pkg::CNT_W-1:0]    release_run;
   logic                          gate_on;
   gate_verdict_type              gate_verdicts [$];

   block_rms_voice_activity_gate_top #(
      .MAX_BLOCK (BLOCK_LIMIT)
   ) u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   function automatic logic [rvag_pkg::CNT_W-1:0] count_up(logic [rvag_pkg::CNT_W-1:0] run,
                                                          logic [12:0] n);
      logic [rvag_pkg::CNT_W:0] total;
      total = {1'b0, run} + {13'd0, n};
      return (total > {1'b0, rvag_pkg::COUNT_MAX}) ? rvag_pkg::COUNT_MAX
                                                   : total[rvag_pkg::CNT_W-1:0];
   endfunction

   function automatic void fold_sample(logic [rvag_pkg::REQ_DAT_W-1:0] raw, logic lst,
                                       logic use_tag, gate_verdict_type tag);
      logic [16:0]      mag;
      logic [63:0]      need;
      gate_verdict_type got;
      mag = raw[15] ? (17'h10000 - {1'b0, raw}) : {1'b0, raw};
      energy_sum = energy_sum + 43'(mag) * 43'(mag);
      beat_count = beat_count + 13'd1;
      if (!lst && beat_count < BLOCK_LIMIT) return;
      need = 64'(beat_count) * 64'(thr_level);
      got.above = (energy_sum != '0) && (64'(energy_sum) >= need);
      if (got.above) begin
         release_run = '0;
         if (!gate_on) begin
            attack_run = count_up(attack_run, beat_count);
            if (attack_run >= {1'b0, attack_len}) begin
               gate_on = 1'b1;
               attack_run = '0;
            end
         end
      end else begin
         attack_run = '0;
         if (gate_on) begin
            release_run = count_up(release_run, beat_count);
            if (release_run >= {1'b0, release_len}) begin
               gate_on = 1'b0;
               release_run = '0;
            end
         end
      end
      energy_sum = '0;
      beat_count = '0;
      got.active = gate_on;
      gate_verdicts.push_back(use_tag ? tag : got);
   endfunction

   always @(posedge clock) begin
      gate_verdict_type want;
      if (reset) begin
         thr_level   = rvag_pkg::THRESHOLD_RESET;
         attack_len  = rvag_pkg::ATTACK_RESET;
         release_len = rvag_pkg::RELEASE_RESET;
         energy_sum  = '0;
         beat_count  = '0;
         attack_run  = '0;
         release_run = '0;
         gate_on     = 1'b0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               rvag_pkg::CSR_THRESHOLD_POWER:
                  thr_level   = csr_wdata[rvag_pkg::THR_W-1:0];
               rvag_pkg::CSR_ATTACK_LENGTH:
                  attack_len  = csr_wdata[rvag_pkg::LENGTH_W-1:0];
               rvag_pkg::CSR_RELEASE_LENGTH:
                  release_len = csr_wdata[rvag_pkg::LENGTH_W-1:0];
               default: ;
            endcase
         end
         if (req_tvalid && req_tready)
            fold_sample(req_tdata, req_tlast, tag_valid, tag_value);
         if (rsp_tvalid && rsp_tready) begin
            if (gate_verdicts.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected result beat: active %0b above %0b",
                           rsp_tdata[0], rsp_tdata[1]);
            end else begin
               want = gate_verdicts.pop_front();
               if (rsp_tdata[0] !== want.active || rsp_tdata[1] !== want.above) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("result mismatch: active exp %0b got %0b, above exp %0b got %0b",
                              want.active, rsp_tdata[0], want.above, rsp_tdata[1]);
               end
            end
         end
      end
   end

   // result side: random stalls, one long hold while samples keep coming
   initial begin
      forever begin
         @(posedge clock);
         if (hold_req && !hold_used) begin
            hold_used = 1'b1;
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         rsp_tready <= calm || ($urandom_range(99) >= 36);
      end
   end

   function automatic plan_row_type beat_row(logic [rvag_pkg::REQ_DAT_W-1:0] pcm, logic lst,
                                             logic act, logic abv);
      plan_row_type row;
      row = '0;
      row.kind = ROW_BEAT;
      row.reg_sel = rvag_pkg::CSR_THRESHOLD_POWER;
      row.pcm = pcm;
      row.lst = lst;
      row.verdict.active = act;
      row.verdict.above = abv;
      return row;
   endfunction

   function automatic plan_row_type write_row(logic [rvag_pkg::CSR_IDX_W-1:0] idx,
                                              logic [rvag_pkg::CSR_DAT_W-1:0] val);
      plan_row_type row;
      row = '0;
      row.kind = ROW_WRITE;
      row.reg_sel = idx;
      row.value = val;
      return row;
   endfunction

   function automatic logic [rvag_pkg::REQ_DAT_W-1:0] pick_sample(level_type lvl);
      case (lvl)
         LEVEL_SILENT: return '0;
         LEVEL_FAINT:  return 16'($urandom_range(0, 8) - 4);
         LEVEL_MID:    return 16'($urandom_range(0, 4095) - 2048);
         LEVEL_FULL:   return 16'($urandom);
         default: begin
            case ($urandom_range(0, 2))
               0:       return 16'h8000;
               1:       return 16'h7FFF;
               default: return 16'h8001;
            endcase
         end
      endcase
   endfunction

   task automatic offer_sample(logic [rvag_pkg::REQ_DAT_W-1:0] pcm, logic lst, logic use_tag,
                               gate_verdict_type tag);
      if (!calm) begin
         while ($urandom_range(99) < 36) begin
            req_tvalid <= 1'b0;
            @(posedge clock);
         end
      end
      req_tvalid <= 1'b1;
      req_tdata  <= pcm;
      req_tlast  <= lst;
      tag_valid  <= use_tag;
      tag_value  <= tag;
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic offer_block(int len, level_type lvl);
      for (int i = 0; i < len; i++)
         offer_sample(pick_sample(lvl), i == len - 1, 1'b0, '0);
   endtask

   task automatic drain_results();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (gate_verdicts.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic poke_reg(logic [rvag_pkg::CSR_IDX_W-1:0] idx,
                           logic [rvag_pkg::CSR_DAT_W-1:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   initial begin
      plan_row_type                  plan [PLAN_LEN];
      logic [rvag_pkg::THR_W-1:0]    thr_pick;
      logic [rvag_pkg::LENGTH_W-1:0] atk_pick;
      logic [rvag_pkg::LENGTH_W-1:0] rel_pick;
      int                            phase_beats;
      int                            len;
      int unsigned                   r;

      plan = '{
         beat_row(16'h0000, 1'b1, 1'b0, 1'b0),
         beat_row(16'h7FFF, 1'b1, 1'b0, 1'b1),
         beat_row(16'h8000, 1'b1, 1'b0, 1'b1),
         beat_row(16'h0001, 1'b0, 1'b0, 1'b0),
         beat_row(16'hFFFF, 1'b1, 1'b0, 1'b0),
         write_row(rvag_pkg::CSR_THRESHOLD_POWER, 31'd0),
         write_row(rvag_pkg::CSR_ATTACK_LENGTH, 31'd0),
         write_row(rvag_pkg::CSR_RELEASE_LENGTH, 31'd0),
         beat_row(16'h0000, 1'b1, 1'b0, 1'b0),
         beat_row(16'h0001, 1'b1, 1'b1, 1'b1),
         beat_row(16'h0000, 1'b1, 1'b0, 1'b0),
         write_row(rvag_pkg::CSR_THRESHOLD_POWER, 31'h7FFFFFFF),
         write_row(CSR_UNUSED, 31'd0),
         beat_row(16'h8000, 1'b1, 1'b0, 1'b0),
         write_row(rvag_pkg::CSR_THRESHOLD_POWER, 31'h40000000),
         beat_row(16'h8000, 1'b1, 1'b1, 1'b1),
         beat_row(16'h7FFF, 1'b1, 1'b0, 1'b0),
         write_row(rvag_pkg::CSR_THRESHOLD_POWER, 31'd0),
         write_row(rvag_pkg::CSR_ATTACK_LENGTH, 31'hFFFFFF),
         write_row(rvag_pkg::CSR_RELEASE_LENGTH, 31'hFFFFFF),
         beat_row(16'd100, 1'b1, 1'b0, 1'b1),
         beat_row(16'd5, 1'b0, 1'b0, 1'b0),
         write_row(rvag_pkg::CSR_THRESHOLD_POWER, 31'h7FFFFFFF),
         beat_row(16'd5, 1'b1, 1'b0, 1'b0),
         write_row(rvag_pkg::CSR_THRESHOLD_POWER, 31'd107374),
         write_row(rvag_pkg::CSR_ATTACK_LENGTH, 31'd2),
         write_row(rvag_pkg::CSR_RELEASE_LENGTH, 31'd3),
         beat_row(16'h4000, 1'b1, 1'b0, 1'b1),
         beat_row(16'hC000, 1'b1, 1'b1, 1'b1),
         beat_row(16'h0000, 1'b0, 1'b0, 1'b0),
         beat_row(16'h0000, 1'b1, 1'b1, 1'b0),
         beat_row(16'h0000, 1'b1, 1'b0, 1'b0)
      };

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (plan[i]) begin
         if (plan[i].kind == ROW_WRITE) begin
            drain_results();
            poke_reg(plan[i].reg_sel, plan[i].value);
         end else begin
            offer_sample(plan[i].pcm, plan[i].lst, 1'b1, plan[i].verdict);
         end
      end

      for (int phase = 0; phase < PHASES; phase++) begin
         drain_results();
         case (phase)
            0: begin
               thr_pick = '0;
               atk_pick = '0;
               rel_pick = '0;
            end
            1: begin
               thr_pick = 31'h7FFFFFFF;
               atk_pick = 24'hFFFFFF;
               rel_pick = 24'hFFFFFF;
            end
            2: begin
               thr_pick = 31'h40000000;
               atk_pick = 24'($urandom_range(0, 48));
               rel_pick = 24'($urandom_range(0, 48));
            end
            default: begin
               thr_pick = 31'($urandom_range(0, 32'd1 << $urandom_range(8, 30)));
               atk_pick = 24'($urandom_range(0, 48));
               rel_pick = 24'($urandom_range(0, 48));
            end
         endcase
         poke_reg(rvag_pkg::CSR_THRESHOLD_POWER, thr_pick);
         poke_reg(rvag_pkg::CSR_ATTACK_LENGTH, {7'($urandom), atk_pick});
         poke_reg(rvag_pkg::CSR_RELEASE_LENGTH, {7'($urandom), rel_pick});
         calm = (phase == 4);

         if (phase == 5) begin
            calm = 1'b1;
            hold_req = 1'b1;
            for (int i = 0; i < BURST_BEATS; i++)
               offer_sample(pick_sample(level_type'($urandom_range(0, 4))), 1'b1, 1'b0, '0);
            calm = 1'b0;
         end

         phase_beats = 0;
         while (phase_beats < PHASE_BEATS) begin
            r = $urandom_range(99);
            if (r < 70)
               len = $urandom_range(1, 8);
            else if (r < 95)
               len = $urandom_range(9, 40);
            else
               len = $urandom_range(41, 200);
            offer_block(len, level_type'($urandom_range(0, 4)));
            phase_beats += len;
         end
      end

      calm = 1'b0;
      drain_results();
      mismatches += gate_verdicts.size();
      if (mismatches == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule

// ----- filelist.f -----
rtl/rvag_pkg.sv
rtl/rvag_front.sv
rtl/rvag_queue.sv
rtl/rvag_back.sv
rtl/block_rms_voice_activity_gate_top.sv
tb/tb_block_rms_voice_activity_gate_top.sv
